// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
// depends on nothing; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("same-cycle check failed");

// next-cycle implication under an active-low reset
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("next-cycle check failed");

`endif

// ===== sv/ris_pkg.sv =====
// shared types and constants of the roi intensity statistics unit
// no dependencies; used by the interfaces, all modules and the checker
package ris_pkg;

	localparam int unsigned REG_IDX_BITS  = 3;
	localparam int unsigned REG_DATA_BITS = 14;

	localparam logic [REG_IDX_BITS-1:0] REG_ENABLE     = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_ROI_LEFT   = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_ROI_TOP    = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_ROI_WIDTH  = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_ROI_HEIGHT = 3'd4;

	localparam int unsigned FIFO_DEPTH = 2;

	typedef struct packed {
		logic [15:0] pixel_value;
		logic [12:0] column;
		logic [12:0] row_index;
		logic        end_of_frame;
	} pixel_t;

	typedef struct packed {
		logic [15:0] minimum_value;
		logic [15:0] maximum_value;
		logic [23:0] mean_value;
		logic [23:0] deviation_value;
		logic [26:0] pixel_count;
		logic        roi_empty;
	} result_t;

	typedef struct packed {
		logic        enable;
		logic [12:0] roi_left;
		logic [12:0] roi_top;
		logic [13:0] roi_width;
		logic [13:0] roi_height;
	} cfg_t;

endpackage

// ===== sv/ris_if.sv =====
// valid/ready channel interfaces for pixel items and result items
// depends on ris_pkg for the payload structs
interface ris_pixel_if import ris_pkg::*; ();
	logic   valid;
	logic   ready;
	pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ris_result_if import ris_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/ris_fifo.sv =====
// short frame-summary queue between the front and the back
// depends on ris_pkg for the queue depth
module ris_fifo import ris_pkg::*; #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             nonempty
);

	localparam int unsigned PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CNT_BITS = $clog2(FIFO_DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] fill_q;
	logic                do_push;
	logic                do_pop;

	assign full     = fill_q == CNT_BITS'(FIFO_DEPTH);
	assign nonempty = fill_q != '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== sv/ris_front.sv =====
// front end: takes pixel items, tests them against the region, accumulates
// min, max, count, sum and sum of squares; depends on ris_pkg and ris_if
module ris_front import ris_pkg::*; #(
	parameter int unsigned PIXEL_BITS = 16,
	parameter int unsigned COORD_BITS = 13
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cfg_t                                   cfg,
	ris_pixel_if.sink                              pixel,
	input  logic                                   full,
	output logic                                   push,
	output logic [PIXEL_BITS-1:0]                  snap_min,
	output logic [PIXEL_BITS-1:0]                  snap_max,
	output logic [2*COORD_BITS:0]                  snap_count,
	output logic [PIXEL_BITS+2*COORD_BITS-1:0]     snap_sum,
	output logic [2*PIXEL_BITS+2*COORD_BITS-1:0]   snap_sqsum
);

	localparam int unsigned CNT_BITS = 2*COORD_BITS + 1;
	localparam int unsigned SUM_BITS = PIXEL_BITS + 2*COORD_BITS;
	localparam int unsigned SQ_BITS  = 2*PIXEL_BITS + 2*COORD_BITS;
	localparam int unsigned SQP_BITS = 2*PIXEL_BITS;

	logic                  valid_s1;
	logic                  inside_s1;
	logic                  eof_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [SQP_BITS-1:0]   sq_s1;

	logic [PIXEL_BITS-1:0] min_q;
	logic [PIXEL_BITS-1:0] max_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [SQ_BITS-1:0]    sqsum_q;

	logic [PIXEL_BITS-1:0] pix_in;
	logic [SQP_BITS-1:0]   sq_in;
	logic [13:0]           col_off;
	logic [13:0]           row_off;
	logic                  inside_in;
	logic                  stall;
	logic                  accept;
	logic                  take;
	logic                  advance;

	logic [PIXEL_BITS-1:0] min_n;
	logic [PIXEL_BITS-1:0] max_n;
	logic [CNT_BITS-1:0]   cnt_n;
	logic [SUM_BITS-1:0]   sum_n;
	logic [SQ_BITS-1:0]    sqsum_n;

	assign pix_in  = pixel.data.pixel_value[PIXEL_BITS-1:0];
	assign sq_in   = SQP_BITS'(pix_in) * SQP_BITS'(pix_in);
	assign col_off = {1'b0, pixel.data.column} - {1'b0, cfg.roi_left};
	assign row_off = {1'b0, pixel.data.row_index} - {1'b0, cfg.roi_top};
	assign inside_in = (pixel.data.column >= cfg.roi_left) && (col_off < cfg.roi_width) &&
		(pixel.data.row_index >= cfg.roi_top) && (row_off < cfg.roi_height);

	// an enabled frame end waits here until the queue has room
	assign stall       = valid_s1 && eof_s1 && cfg.enable && full;
	assign pixel.ready = !stall;
	assign accept      = pixel.valid && !stall;
	assign advance     = valid_s1 && !stall;

	// count saturates at the top power of two
	assign take    = inside_s1 && !cnt_q[CNT_BITS-1];
	assign min_n   = (take && (pix_s1 < min_q)) ? pix_s1 : min_q;
	assign max_n   = (take && (pix_s1 > max_q)) ? pix_s1 : max_q;
	assign cnt_n   = cnt_q + CNT_BITS'(take);
	assign sum_n   = sum_q + (take ? SUM_BITS'(pix_s1) : '0);
	assign sqsum_n = sqsum_q + (take ? SQ_BITS'(sq_s1) : '0);

	assign push       = advance && eof_s1 && cfg.enable;
	assign snap_min   = min_n;
	assign snap_max   = max_n;
	assign snap_count = cnt_n;
	assign snap_sum   = sum_n;
	assign snap_sqsum = sqsum_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1    <= pix_in;
			sq_s1     <= sq_in;
			inside_s1 <= inside_in;
			eof_s1    <= pixel.data.end_of_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '1;
			max_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
		end else if (advance) begin
			if (eof_s1) begin
				min_q   <= '1;
				max_q   <= '0;
				cnt_q   <= '0;
				sum_q   <= '0;
				sqsum_q <= '0;
			end else begin
				min_q   <= min_n;
				max_q   <= max_n;
				cnt_q   <= cnt_n;
				sum_q   <= sum_n;
				sqsum_q <= sqsum_n;
			end
		end
	end

endmodule

// ===== sv/ris_back.sv =====
// back end: turns one frame summary into a result item with a serial
// shift-add multiplier, a restoring divider and a digit square root
// depends on ris_pkg and ris_if
module ris_back import ris_pkg::*; #(
	parameter int unsigned PIXEL_BITS    = 16,
	parameter int unsigned COORD_BITS    = 13,
	parameter int unsigned FRACTION_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 fifo_valid,
	output logic                                 pop,
	input  logic [PIXEL_BITS-1:0]                snap_min,
	input  logic [PIXEL_BITS-1:0]                snap_max,
	input  logic [2*COORD_BITS:0]                snap_count,
	input  logic [PIXEL_BITS+2*COORD_BITS-1:0]   snap_sum,
	input  logic [2*PIXEL_BITS+2*COORD_BITS-1:0] snap_sqsum,
	ris_result_if.source                         result
);

	localparam int unsigned CNT_BITS = 2*COORD_BITS + 1;
	localparam int unsigned SUM_BITS = PIXEL_BITS + 2*COORD_BITS;
	localparam int unsigned SQ_BITS  = 2*PIXEL_BITS + 2*COORD_BITS;
	localparam int unsigned MW       = SQ_BITS + SUM_BITS;
	localparam int unsigned YW       = SUM_BITS;
	localparam int unsigned DW       = 2*CNT_BITS;
	localparam int unsigned NW       = MW + 2*FRACTION_BITS;
	localparam int unsigned RT       = PIXEL_BITS + FRACTION_BITS;
	localparam int unsigned QW       = 2*RT;
	localparam int unsigned SW       = $clog2(NW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAN,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_N,
		ST_DEV,
		ST_SQRT,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic [SW-1:0]   cnt_q;
	logic            res_valid_q;
	result_t         res_q;

	logic [PIXEL_BITS-1:0] min_snap_q;
	logic [PIXEL_BITS-1:0] max_snap_q;
	logic [CNT_BITS-1:0]   cnt_snap_q;
	logic [SUM_BITS-1:0]   sum_snap_q;
	logic [SQ_BITS-1:0]    sq_snap_q;

	logic [MW-1:0]   mul_x_q;
	logic [YW-1:0]   mul_y_q;
	logic [MW-1:0]   prod_q;
	logic [MW-1:0]   a_q;
	logic [MW-1:0]   diff_q;
	logic [NW-1:0]   num_q;
	logic [DW-1:0]   div_d_q;
	logic [DW-1:0]   rem_q;
	logic [QW-1:0]   quo_q;
	logic [QW-1:0]   rad_q;
	logic [RT-1:0]   sq_rem_q;
	logic [RT-1:0]   root_q;
	logic [23:0]     mean_q;
	logic [23:0]     dev_q;

	logic [MW-1:0]   prod_add;
	logic [DW:0]     div_trial;
	logic [DW:0]     div_sub;
	logic            div_ge;
	logic [DW-1:0]   rem_n;
	logic [QW-1:0]   quo_n;
	logic [RT+1:0]   sq_cand;
	logic [RT+1:0]   sq_trial;
	logic [RT+1:0]   sq_sub;
	logic            sq_ge;
	logic [RT-1:0]   sq_rem_n;
	logic [RT-1:0]   root_n;
	logic [63:0]     mean_w;
	logic [63:0]     dev_w;
	logic [63:0]     count_w;
	logic            n_zero;
	logic            step_last;
	logic            out_free;
	result_t         res_n;

	assign prod_add = prod_q + (mul_y_q[0] ? mul_x_q : '0);

	assign div_trial = {rem_q, num_q[NW-1]};
	assign div_sub   = div_trial - {1'b0, div_d_q};
	assign div_ge    = div_trial >= {1'b0, div_d_q};
	assign rem_n     = div_ge ? div_sub[DW-1:0] : div_trial[DW-1:0];
	assign quo_n     = {quo_q[QW-2:0], div_ge};

	assign sq_cand  = {sq_rem_q, rad_q[QW-1:QW-2]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_sub   = sq_cand - sq_trial;
	assign sq_ge    = sq_cand >= sq_trial;
	assign sq_rem_n = sq_ge ? sq_sub[RT-1:0] : sq_cand[RT-1:0];
	assign root_n   = {root_q[RT-2:0], sq_ge};

	assign mean_w  = 64'(quo_n);
	assign dev_w   = 64'(root_n);
	assign count_w = 64'(cnt_snap_q);
	assign n_zero  = cnt_snap_q == '0;

	always_comb begin
		case (state_q)
			ST_MEAN, ST_DEV:            step_last = cnt_q == SW'(NW - 1);
			ST_MUL_A, ST_MUL_B, ST_MUL_N: step_last = cnt_q == SW'(YW - 1);
			ST_SQRT:                    step_last = cnt_q == SW'(RT - 1);
			default:                    step_last = 1'b0;
		endcase
	end

	always_comb begin
		res_n.minimum_value   = n_zero ? 16'd0 : 16'(min_snap_q);
		res_n.maximum_value   = n_zero ? 16'd0 : 16'(max_snap_q);
		res_n.mean_value      = mean_q;
		res_n.deviation_value = dev_q;
		res_n.pixel_count     = count_w[26:0];
		res_n.roi_empty       = n_zero;
	end

	assign pop          = (state_q == ST_IDLE) && fifo_valid;
	assign out_free     = !res_valid_q || result.ready;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (state_q != ST_IDLE && state_q != ST_DONE) begin
				cnt_q <= step_last ? '0 : cnt_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (fifo_valid) begin
						state_q <= (snap_count == '0) ? ST_DONE : ST_MEAN;
					end
				end
				ST_MEAN: begin
					if (step_last) state_q <= ST_MUL_A;
				end
				ST_MUL_A: begin
					if (step_last) state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					if (step_last) state_q <= (a_q >= prod_add) ? ST_MUL_N : ST_DONE;
				end
				ST_MUL_N: begin
					if (step_last) state_q <= ST_DEV;
				end
				ST_DEV: begin
					if (step_last) state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (step_last) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						res_q   <= res_n;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (fifo_valid) begin
					min_snap_q <= snap_min;
					max_snap_q <= snap_max;
					cnt_snap_q <= snap_count;
					sum_snap_q <= snap_sum;
					sq_snap_q  <= snap_sqsum;
					mean_q     <= '0;
					dev_q      <= '0;
					num_q      <= NW'(snap_sum) << FRACTION_BITS;
					div_d_q    <= DW'(snap_count);
					rem_q      <= '0;
					quo_q      <= '0;
				end
			end
			ST_MEAN: begin
				num_q <= num_q << 1;
				rem_q <= rem_n;
				quo_q <= quo_n;
				if (step_last) begin
					mean_q  <= mean_w[23:0];
					mul_x_q <= MW'(sq_snap_q);
					mul_y_q <= YW'(cnt_snap_q);
					prod_q  <= '0;
				end
			end
			ST_MUL_A: begin
				prod_q  <= prod_add;
				mul_x_q <= mul_x_q << 1;
				mul_y_q <= mul_y_q >> 1;
				if (step_last) begin
					a_q     <= prod_add;
					mul_x_q <= MW'(sum_snap_q);
					mul_y_q <= sum_snap_q;
					prod_q  <= '0;
				end
			end
			ST_MUL_B: begin
				prod_q  <= prod_add;
				mul_x_q <= mul_x_q << 1;
				mul_y_q <= mul_y_q >> 1;
				if (step_last) begin
					diff_q  <= a_q - prod_add;
					mul_x_q <= MW'(cnt_snap_q);
					mul_y_q <= YW'(cnt_snap_q);
					prod_q  <= '0;
				end
			end
			ST_MUL_N: begin
				prod_q  <= prod_add;
				mul_x_q <= mul_x_q << 1;
				mul_y_q <= mul_y_q >> 1;
				if (step_last) begin
					num_q   <= NW'(diff_q) << (2*FRACTION_BITS);
					div_d_q <= prod_add[DW-1:0];
					rem_q   <= '0;
					quo_q   <= '0;
				end
			end
			ST_DEV: begin
				num_q <= num_q << 1;
				rem_q <= rem_n;
				quo_q <= quo_n;
				if (step_last) begin
					rad_q    <= quo_n;
					sq_rem_q <= '0;
					root_q   <= '0;
				end
			end
			ST_SQRT: begin
				rad_q    <= rad_q << 2;
				sq_rem_q <= sq_rem_n;
				root_q   <= root_n;
				if (step_last) begin
					dev_q <= dev_w[23:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/roi_intensity_statistics_unit.sv =====
// pixels are taken one per cycle; a frame end that finds the summary queue full waits there
// the result of a frame follows its frame-end pixel through the front register, the summary
// queue and the back end, which works through a serial division for the mean, three serial
// multiplications, a serial division for the deviation and a serial square root; it
// handles one frame summary at a time
// reset clears the registers and the accumulators at once; there is no clearing pass
module roi_intensity_statistics_unit import ris_pkg::*; #(
	parameter int unsigned PIXEL_BITS    = 16,
	parameter int unsigned COORD_BITS    = 13,
	parameter int unsigned FRACTION_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [REG_IDX_BITS-1:0]  cfg_index,
	input  logic [REG_DATA_BITS-1:0] cfg_data,
	ris_pixel_if.sink                pixel,
	ris_result_if.source             result
);

	localparam int unsigned CNT_BITS  = 2*COORD_BITS + 1;
	localparam int unsigned SUM_BITS  = PIXEL_BITS + 2*COORD_BITS;
	localparam int unsigned SQ_BITS   = 2*PIXEL_BITS + 2*COORD_BITS;
	localparam int unsigned SNAP_BITS = 2*PIXEL_BITS + CNT_BITS + SUM_BITS + SQ_BITS;

	cfg_t                  cfg_q;
	logic                  push;
	logic                  full;
	logic                  pop;
	logic                  nonempty;
	logic [SNAP_BITS-1:0]  push_data;
	logic [SNAP_BITS-1:0]  pop_data;

	logic [PIXEL_BITS-1:0] f_min;
	logic [PIXEL_BITS-1:0] f_max;
	logic [CNT_BITS-1:0]   f_count;
	logic [SUM_BITS-1:0]   f_sum;
	logic [SQ_BITS-1:0]    f_sqsum;
	logic [PIXEL_BITS-1:0] b_min;
	logic [PIXEL_BITS-1:0] b_max;
	logic [CNT_BITS-1:0]   b_count;
	logic [SUM_BITS-1:0]   b_sum;
	logic [SQ_BITS-1:0]    b_sqsum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:     cfg_q.enable     <= cfg_data[0];
				REG_ROI_LEFT:   cfg_q.roi_left   <= cfg_data[12:0];
				REG_ROI_TOP:    cfg_q.roi_top    <= cfg_data[12:0];
				REG_ROI_WIDTH:  cfg_q.roi_width  <= cfg_data[13:0];
				REG_ROI_HEIGHT: cfg_q.roi_height <= cfg_data[13:0];
				default: begin
				end
			endcase
		end
	end

	ris_front #(
		.PIXEL_BITS (PIXEL_BITS),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pixel      (pixel),
		.full       (full),
		.push       (push),
		.snap_min   (f_min),
		.snap_max   (f_max),
		.snap_count (f_count),
		.snap_sum   (f_sum),
		.snap_sqsum (f_sqsum)
	);

	assign push_data = {f_min, f_max, f_count, f_sum, f_sqsum};
	assign {b_min, b_max, b_count, b_sum, b_sqsum} = pop_data;

	ris_fifo #(
		.WIDTH (SNAP_BITS)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.nonempty  (nonempty)
	);

	ris_back #(
		.PIXEL_BITS    (PIXEL_BITS),
		.COORD_BITS    (COORD_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_valid (nonempty),
		.pop        (pop),
		.snap_min   (b_min),
		.snap_max   (b_max),
		.snap_count (b_count),
		.snap_sum   (b_sum),
		.snap_sqsum (b_sqsum),
		.result     (result)
	);

endmodule

// ===== sv/ris_checker.sv =====
// port-level checks on the result channel of the top level, bound to it below
// depends on ris_pkg and assert_macros.svh
`include "assert_macros.svh"

module ris_checker import ris_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result_data
);

	`ASSERT_NEXT(a_valid_hold, clk, arst_n, result_valid && !result_ready, result_valid)
	`ASSERT_NEXT(a_data_hold, clk, arst_n, result_valid && !result_ready, $stable(result_data))
	`ASSERT_IMPLIES(a_empty_zero, clk, arst_n, result_valid && result_data.roi_empty, result_data.minimum_value == 16'd0 && result_data.maximum_value == 16'd0 && result_data.mean_value == 24'd0 && result_data.deviation_value == 24'd0 && result_data.pixel_count == 27'd0)
	`ASSERT_IMPLIES(a_min_le_max, clk, arst_n, result_valid && !result_data.roi_empty, result_data.minimum_value <= result_data.maximum_value)

endmodule

bind roi_intensity_statistics_unit ris_checker u_ris_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);
